>>> rtl/core/pfct_pkg.sv
// Shared types and codes for the Pareto front cell table.
package pfct_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_DOMINATED = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_LISTED    = 3'd4;
    localparam t_status ST_EMPTY     = 3'd5;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_LIST = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESULT,
        S_EMIT
    } t_state;

endpackage

>>> rtl/core/pareto_front_cell_table.sv
// Pareto front cell table: a store of cells, each a bounded set of mutually nondominated
// two-objective vectors, addressed by time step and joint state. After reset the block
// runs a clearing pass, one entry a cycle, over all 2**(clog2(TIME_STEPS) + AGENTS +
// clog2(CAPACITY)) entries of the entry memory, each logarithm taken as at least one
// (512 with the default parameters), and takes no item until it is done. An item then
// walks the CAPACITY slots of its cell, one slot a cycle, through the single read port of
// the entry memory; the insert is written as the scan ends, before the result beat is
// loaded. An add gives one result beat. A list gives one beat per stored entry, sorted
// ascending by a and then by b, at one beat a cycle when the output is not stalled, or a
// single ST_EMPTY beat when the cell holds none. A new item is taken as soon as the last
// result beat of the previous one has moved into the output register, even while that
// beat still waits to be taken.
module pareto_front_cell_table #(
    parameter int TIME_STEPS  = 16,
    parameter int AGENTS      = 2,
    parameter int CAPACITY    = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_opcode,
    input  logic [3:0]          i_time_step,
    input  logic [1:0]          i_cell_state,
    input  logic signed [15:0]  i_value_a,
    input  logic signed [15:0]  i_value_b,
    output logic                o_valid,
    input  logic                i_stall,
    output pfct_pkg::t_status   o_status,
    output logic [3:0]          o_removed_count,
    output logic signed [15:0]  o_entry_a,
    output logic signed [15:0]  o_entry_b,
    output logic                o_last
);
    import pfct_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int TW  = (TIME_STEPS > 1) ? $clog2(TIME_STEPS) : 1;
    localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW1 = $clog2(CAPACITY + 1);
    localparam int CW  = TW + AGENTS;
    localparam int AW  = CW + SW;
    localparam int DW  = 2 * VW + 1;
    localparam int DEPTH = 1 << AW;
    localparam logic [SW1-1:0] CAP1 = SW1'(CAPACITY);

    // Entry memory: {valid, a, b}.
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [AW-1:0]          r_clr_addr;
    logic                   r_op;
    logic [CW-1:0]          r_cell;
    logic signed [VW-1:0]   r_va, r_vb;
    logic [SW1-1:0]         r_rd_slot;
    logic                   r_chk_valid;
    logic [SW-1:0]          r_chk_slot;
    logic                   r_hit;
    t_status                r_hit_status;
    logic [SW1-1:0]         r_evict_cnt;
    logic                   r_free_found;
    logic [SW-1:0]          r_free_slot;
    logic signed [VW-1:0]   r_sa [CAPACITY];
    logic signed [VW-1:0]   r_sb [CAPACITY];
    logic [SW1-1:0]         r_sort_cnt;

    logic                   r_out_valid;
    t_status                r_status;
    logic [3:0]             r_removed;
    logic signed [15:0]     r_entry_a, r_entry_b;
    logic                   r_last;

    // Address and value preparation.
    logic [TW-1:0]          w_tmod [16];
    logic [AGENTS+1:0]      w_s_ext;
    logic [VW+15:0]         w_va_ext, w_vb_ext;

    for (genvar k = 0; k < 16; k++) begin : g_tmod
        localparam int unsigned TM = k % TIME_STEPS;
        assign w_tmod[k] = TW'(TM);
    end

    assign w_s_ext  = {{AGENTS{1'b0}}, i_cell_state};
    assign w_va_ext = {{VW{1'b0}}, i_value_a};
    assign w_vb_ext = {{VW{1'b0}}, i_value_b};

    // Decode of the entry that arrives from memory.
    logic                   w_e_valid;
    logic signed [VW-1:0]   w_ea, w_eb;
    logic                   w_vg, w_eg, w_dup, w_v_dom, w_e_dom;

    assign w_e_valid = r_rd_data[DW-1];
    assign w_ea      = r_rd_data[2*VW-1:VW];
    assign w_eb      = r_rd_data[VW-1:0];
    assign w_vg      = (r_va > w_ea) || (r_vb > w_eb);
    assign w_eg      = (w_ea > r_va) || (w_eb > r_vb);
    assign w_dup     = !w_vg && !w_eg;
    assign w_v_dom   = w_vg && !w_eg;
    assign w_e_dom   = w_eg && !w_vg;

    // Control decode.
    logic                   w_accept, w_out_free, w_issue, w_chk, w_scan_done, w_add;
    logic                   w_evict, w_insert, w_sort_ins, w_sort_shift, w_load_out;
    logic                   w_mem_we;
    logic [AW-1:0]          w_mem_waddr, w_mem_raddr;
    logic [DW-1:0]          w_mem_wdata;

    always_comb begin
        o_stall     = (r_state != S_IDLE);
        w_accept    = i_valid && (r_state == S_IDLE);
        w_out_free  = !r_out_valid || !i_stall;
        w_add       = (r_op == OP_ADD);
        w_issue     = (r_state == S_SCAN) && (r_rd_slot != CAP1);
        w_chk       = (r_state == S_SCAN) && r_chk_valid;
        w_scan_done = (r_state == S_SCAN) && (r_rd_slot == CAP1) && !r_chk_valid;
        w_evict     = w_chk && w_add && w_e_valid && w_v_dom;
        w_insert    = w_scan_done && w_add && !r_hit && r_free_found;
        w_sort_ins  = w_chk && !w_add && w_e_valid;
        w_load_out  = ((r_state == S_RESULT) || (r_state == S_EMIT)) && w_out_free;
        w_sort_shift = (r_state == S_EMIT) && w_out_free;
        w_mem_raddr = {r_cell, r_rd_slot[SW-1:0]};
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr_addr;
        w_mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_mem_we = 1'b1;
        end else if (w_evict) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = {r_cell, r_chk_slot};
        end else if (w_insert) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = {r_cell, r_free_slot};
            w_mem_wdata = {1'b1, r_va, r_vb};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = (w_add || (r_sort_cnt == '0)) ? S_RESULT : S_EMIT;
                end
            end
            S_RESULT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free && (r_sort_cnt == SW1'(1))) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= mem[w_mem_raddr];
    end

    // Scan bookkeeping. Stored entries never dominate one another, so a vector that evicts
    // an entry can never also be a duplicate of or dominated by another entry: eviction
    // is written back as soon as each entry has been checked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            r_chk_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= i_opcode;
            r_cell       <= {w_tmod[i_time_step], w_s_ext[AGENTS-1:0]};
            r_va         <= w_va_ext[VW-1:0];
            r_vb         <= w_vb_ext[VW-1:0];
            r_rd_slot    <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_evict_cnt  <= '0;
        end else begin
            if (w_issue) begin
                r_rd_slot  <= r_rd_slot + SW1'(1);
                r_chk_slot <= r_rd_slot[SW-1:0];
            end
            if (w_chk && w_add && w_e_valid && !r_hit && (w_dup || w_e_dom)) begin
                r_hit        <= 1'b1;
                r_hit_status <= w_dup ? ST_DUPLICATE : ST_DOMINATED;
            end
            if (w_chk && w_add && !r_free_found && (!w_e_valid || w_v_dom)) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_chk_slot;
            end
            if (w_evict) r_evict_cnt <= r_evict_cnt + SW1'(1);
        end
    end

    // Sort buffer for a list: insertion on the way in, shift from the head on the way out.
    logic                   w_less [CAPACITY];
    logic signed [VW-1:0]   w_ins_a [CAPACITY], w_ins_b [CAPACITY];
    logic signed [VW-1:0]   w_shf_a [CAPACITY], w_shf_b [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_sort
        assign w_less[k] = (SW1'(k) < r_sort_cnt) &&
                           ((r_sa[k] < w_ea) || ((r_sa[k] == w_ea) && (r_sb[k] < w_eb)));
        if (k == 0) begin : g_head
            assign w_ins_a[k] = w_less[k] ? r_sa[k] : w_ea;
            assign w_ins_b[k] = w_less[k] ? r_sb[k] : w_eb;
        end else begin : g_body
            assign w_ins_a[k] = w_less[k] ? r_sa[k] : (w_less[k-1] ? w_ea : r_sa[k-1]);
            assign w_ins_b[k] = w_less[k] ? r_sb[k] : (w_less[k-1] ? w_eb : r_sb[k-1]);
        end
        if (k == CAPACITY - 1) begin : g_tail
            assign w_shf_a[k] = r_sa[k];
            assign w_shf_b[k] = r_sb[k];
        end else begin : g_mid
            assign w_shf_a[k] = r_sa[k+1];
            assign w_shf_b[k] = r_sb[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_sort_ins) begin
                r_sa[k] <= w_ins_a[k];
                r_sb[k] <= w_ins_b[k];
            end else if (w_sort_shift) begin
                r_sa[k] <= w_shf_a[k];
                r_sb[k] <= w_shf_b[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_cnt <= '0;
        end else if (w_accept) begin
            r_sort_cnt <= '0;
        end else if (w_sort_ins) begin
            r_sort_cnt <= r_sort_cnt + SW1'(1);
        end else if (w_sort_shift) begin
            r_sort_cnt <= r_sort_cnt - SW1'(1);
        end
    end

    // Output register.
    logic [VW+15:0]         w_oa_ext, w_ob_ext;
    logic [SW1+3:0]         w_rem_ext;

    assign w_oa_ext  = {16'b0, r_sa[0]};
    assign w_ob_ext  = {16'b0, r_sb[0]};
    assign w_rem_ext = {4'b0, r_evict_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_removed <= '0;
            r_entry_a <= '0;
            r_entry_b <= '0;
            r_last    <= 1'b1;
            if (r_state == S_EMIT) begin
                r_status  <= ST_LISTED;
                r_entry_a <= w_oa_ext[15:0];
                r_entry_b <= w_ob_ext[15:0];
                r_last    <= (r_sort_cnt == SW1'(1));
            end else if (!w_add) begin
                r_status <= ST_EMPTY;
            end else if (r_hit) begin
                r_status <= r_hit_status;
            end else if (!r_free_found) begin
                r_status <= ST_FULL;
            end else begin
                r_status  <= ST_INSERTED;
                r_removed <= w_rem_ext[3:0];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_count = r_removed;
    assign o_entry_a       = r_entry_a;
    assign o_entry_b       = r_entry_b;
    assign o_last          = r_last;

    // Checks.
    a_no_evict_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_evict && w_insert))
        else $error("eviction and insert write in the same cycle");

    a_sort_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sort_cnt <= CAP1)
        else $error("sort buffer count above capacity");

    a_removed_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_INSERTED)) |-> (o_removed_count == 4'd0))
        else $error("evicted count on a result that is not an insert");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

endmodule
